/* hw/rtl/tlm_pkg.sv */
// ----------------------------------------------------------------------------
// tlm_pkg
// Shared types, codes and helpers of the throughput level monitor.
// ----------------------------------------------------------------------------
package tlm_pkg;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_TX   = 2'd1,
    OP_TICK = 2'd2,
    OP_OVR  = 2'd3
  } op_t;

  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_HIGH = 2'd2;
  localparam logic [1:0] LVL_OVR  = 2'd3;

  localparam logic [1:0] DIR_RX = 2'd1;
  localparam logic [1:0] DIR_TX = 2'd2;

  localparam int REG_W = 3;
  localparam logic [REG_W-1:0] REG_CLIENT_MODE = 3'd0;
  localparam logic [REG_W-1:0] REG_DIRECTION   = 3'd1;
  localparam logic [REG_W-1:0] REG_MID_THR     = 3'd2;
  localparam logic [REG_W-1:0] REG_HIGH_THR    = 3'd3;
  localparam logic [REG_W-1:0] REG_HYST_RISE   = 3'd4;
  localparam logic [REG_W-1:0] REG_HYST_FALL   = 3'd5;

  localparam logic [15:0] RX_HDR_BYTES = 16'd40;
  localparam logic [15:0] TX_HDR_BYTES = 16'd50;

  // byte count times 8 over a 16-bit millisecond count
  localparam int DVD_W = 35;
  localparam int DVS_W = 16;
  localparam int DIV_CNT_W = 6;

  localparam logic [31:0] BPS_MAX = 32'hFFFF_FFFF;
  localparam logic [9:0]  MS_PER_S = 10'd1000;
  // largest quotient whose product with 1000 still fits 32 bits
  localparam logic [DVD_W-1:0] QUO_MAX = DVD_W'(32'hFFFF_FFFF / 1000);
  localparam int QUO_USE_W = 23;

  typedef struct packed {
    logic pkt_rx;
    logic pkt_tx;
    logic tick_start;
    logic ovr_start;
    logic div_load;
    logic scale;
    logic accum;
    logic level_upd;
    logic out_load;
  } tlm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } tlm_status_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? BPS_MAX : s[31:0];
  endfunction

endpackage

/* hw/rtl/tlm_div.sv */
// ----------------------------------------------------------------------------
// tlm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tlm_pkg::DVD_W-1:0]   dividend,
  input  logic [tlm_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [tlm_pkg::DVD_W-1:0]   quotient
);
  import tlm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DVD_W-1:0]     quo;
  logic [DVS_W:0]       trial;
  logic                 fits;

  assign trial    = {rem, quo[DVD_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/tlm_datapath.sv */
// ----------------------------------------------------------------------------
// tlm_datapath
// Byte counters, config registers, rate conversion, level hysteresis and
// the output register.
// ----------------------------------------------------------------------------
module tlm_datapath #(
  parameter int NUM_IFACES = 4,
  parameter int IFC_W = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tlm_pkg::tlm_cmd_t          cmd,
  output tlm_pkg::tlm_status_t       status,
  input  logic [IFC_W-1:0]           ifc_sel,
  input  logic                       side_sel,
  input  logic [1:0]                 iface,
  input  logic [15:0]                pkt_length,
  input  logic [15:0]                elapsed_ms,
  input  logic                       cfg_we,
  input  logic [tlm_pkg::REG_W-1:0]  cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [31:0]                out_tx_bps,
  output logic [31:0]                out_rx_bps,
  output logic [1:0]                 out_level,
  output logic                       out_notify
);
  import tlm_pkg::*;

  // config
  logic        client_mode;
  logic [1:0]  direction;
  logic [31:0] mid_thr;
  logic [31:0] high_thr;
  logic [7:0]  rise_limit;
  logic [7:0]  fall_limit;

  logic [31:0] rx_cnt [NUM_IFACES];
  logic [31:0] tx_cnt [NUM_IFACES];
  logic [15:0] rx_len;
  logic [15:0] tx_len;

  logic [15:0] ms_reg;
  logic [31:0] sel_cnt;
  logic        div_done;
  logic [DVD_W-1:0] quo;
  logic [QUO_USE_W+9:0] prod;
  logic [31:0] scaled;
  logic [31:0] tx_sum;
  logic [31:0] rx_sum;

  logic [1:0]  cur_level;
  logic [15:0] hyst;
  logic [1:0]  res_level;
  logic        res_note;

  logic [31:0] comp;
  logic        above_high;
  logic        above_mid;
  logic        step_en;
  logic [7:0]  limit;
  logic [1:0]  target;
  logic        go;
  logic [15:0] hyst_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_mode <= 1'b1;
      direction   <= 2'd0;
      mid_thr     <= 32'd100000000;
      high_thr    <= 32'd200000000;
      rise_limit  <= 8'd2;
      fall_limit  <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIENT_MODE: client_mode <= cfg_data[0];
        REG_DIRECTION:   direction   <= cfg_data[1:0];
        REG_MID_THR:     mid_thr     <= cfg_data;
        REG_HIGH_THR:    high_thr    <= cfg_data;
        REG_HYST_RISE:   rise_limit  <= cfg_data[7:0];
        REG_HYST_FALL:   fall_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign rx_len = (pkt_length >= RX_HDR_BYTES) ? pkt_length - RX_HDR_BYTES : pkt_length;
  assign tx_len = (pkt_length > TX_HDR_BYTES) ? pkt_length - TX_HDR_BYTES : pkt_length;

  // one counter lane per interface, cleared as the tick walk reads it
  for (genvar i = 0; i < NUM_IFACES; i++) begin : g_lane
    logic hit;
    logic sel;
    assign hit = 32'(iface) == 32'(i);
    assign sel = cmd.div_load && (ifc_sel == IFC_W'(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        rx_cnt[i] <= '0;
        tx_cnt[i] <= '0;
      end else begin
        if (cmd.pkt_rx && hit) begin
          rx_cnt[i] <= sat_add32(rx_cnt[i], {16'd0, rx_len});
        end else if (sel && side_sel) begin
          rx_cnt[i] <= '0;
        end
        if (cmd.pkt_tx && hit) begin
          tx_cnt[i] <= sat_add32(tx_cnt[i], {16'd0, tx_len});
        end else if (sel && !side_sel) begin
          tx_cnt[i] <= '0;
        end
      end
    end
  end

  assign sel_cnt = side_sel ? rx_cnt[ifc_sel] : tx_cnt[ifc_sel];

  tlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_load),
    .dividend ({sel_cnt, 3'b000}),
    .divisor  (ms_reg),
    .done     (div_done),
    .quotient (quo)
  );

  assign prod = quo[QUO_USE_W-1:0] * MS_PER_S;

  // level decision
  always_comb begin
    if (direction == DIR_RX) begin
      comp = rx_sum;
    end else if (direction == DIR_TX) begin
      comp = tx_sum;
    end else begin
      comp = sat_add32(tx_sum, rx_sum);
    end
    above_high = (high_thr != 32'd0) && (comp > high_thr);
    above_mid  = (mid_thr != 32'd0) && (comp > mid_thr);
    if (above_high) begin
      step_en = cur_level != LVL_HIGH;
      limit   = rise_limit;
      target  = LVL_HIGH;
    end else if (above_mid) begin
      step_en = (cur_level == LVL_LOW) || (cur_level == LVL_HIGH);
      limit   = (cur_level == LVL_LOW) ? rise_limit : fall_limit;
      target  = LVL_MID;
    end else begin
      step_en = cur_level != LVL_LOW;
      limit   = fall_limit;
      target  = LVL_LOW;
    end
    go       = hyst > {8'd0, limit};
    hyst_inc = (hyst == 16'hFFFF) ? hyst : hyst + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level <= LVL_LOW;
      hyst      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        ms_reg <= elapsed_ms;
        tx_sum <= '0;
        rx_sum <= '0;
      end
      if (cmd.ovr_start) begin
        cur_level <= LVL_OVR;
        tx_sum    <= '0;
        rx_sum    <= '0;
        res_level <= LVL_OVR;
        res_note  <= 1'b1;
      end
      if (cmd.scale) begin
        if (ms_reg == 16'd0) begin
          scaled <= '0;
        end else if (quo > QUO_MAX) begin
          scaled <= BPS_MAX;
        end else begin
          scaled <= prod[31:0];
        end
      end
      if (cmd.accum) begin
        if (side_sel) begin
          rx_sum <= sat_add32(rx_sum, scaled);
        end else begin
          tx_sum <= sat_add32(tx_sum, scaled);
        end
      end
      if (cmd.level_upd) begin
        if (!client_mode) begin
          res_level <= LVL_LOW;
          res_note  <= 1'b1;
        end else if (step_en && go) begin
          cur_level <= target;
          hyst      <= '0;
          res_level <= target;
          res_note  <= 1'b1;
        end else begin
          if (step_en) begin
            hyst <= hyst_inc;
          end
          res_level <= cur_level;
          res_note  <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tx_bps <= tx_sum;
      out_rx_bps <= rx_sum;
      out_level  <= res_level;
      out_notify <= res_note;
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

/* hw/rtl/tlm_ctrl.sv */
// ----------------------------------------------------------------------------
// tlm_ctrl
// Sequencer: takes packet words, walks the interfaces on a tick and hands
// results to the output register.
// ----------------------------------------------------------------------------
module tlm_ctrl #(
  parameter int NUM_IFACES = 4,
  parameter int IFC_W = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  tlm_pkg::op_t          op,
  output logic                  in_ready,
  input  tlm_pkg::tlm_status_t  status,
  output tlm_pkg::tlm_cmd_t     cmd,
  output logic [IFC_W-1:0]      ifc_sel,
  output logic                  side_sel
);
  import tlm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_SCALE,
    S_ACCUM,
    S_LEVEL,
    S_OUT
  } state_t;

  state_t state;
  logic   take;
  logic   last;

  assign in_ready = state == S_IDLE;
  assign take     = in_ready && in_valid;
  assign last     = side_sel && (ifc_sel == IFC_W'(NUM_IFACES - 1));

  always_comb begin
    cmd            = '0;
    cmd.pkt_rx     = take && (op == OP_RX);
    cmd.pkt_tx     = take && (op == OP_TX);
    cmd.tick_start = take && (op == OP_TICK);
    cmd.ovr_start  = take && (op == OP_OVR);
    cmd.div_load   = state == S_LOAD;
    cmd.scale      = state == S_SCALE;
    cmd.accum      = state == S_ACCUM;
    cmd.level_upd  = state == S_LEVEL;
    cmd.out_load   = (state == S_OUT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ifc_sel  <= '0;
      side_sel <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take && (op == OP_TICK)) begin
            state    <= S_LOAD;
            ifc_sel  <= '0;
            side_sel <= 1'b0;
          end else if (take && (op == OP_OVR)) begin
            state <= S_OUT;
          end
        end
        S_LOAD: state <= S_DIV;
        S_DIV: begin
          if (status.div_done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: state <= S_ACCUM;
        S_ACCUM: begin
          if (last) begin
            state <= S_LEVEL;
          end else begin
            state    <= S_LOAD;
            side_sel <= !side_sel;
            if (side_sel) begin
              ifc_sel <= ifc_sel + 1'b1;
            end
          end
        end
        S_LEVEL: state <= S_OUT;
        S_OUT: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/throughput_level_monitor.sv */
// ----------------------------------------------------------------------------
// throughput_level_monitor
// Per-interface byte counting with tick-driven conversion to bits per
// second and a LOW/MID/HIGH level with hysteresis, or OVR on an override word.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                      | contents
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | op in tuser, packet or tick
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | rates, level, notify
//  cfg      | in  | cfg_valid / cfg_ready          | register index and data
//
//  packet words are taken one per cycle while idle; a tick holds tready low
//  while the one-bit-per-cycle divider, shared by every interface and direction,
//  works through each count (load, 35 divide steps, done, scale, add), then
//  through level and output, plus any output stall
//  an override word holds tready low in the output state plus any output stall
//  reset is synchronous; counters and level clear at once, no clearing pass
//  a stalled result holds in the output register; packets are still taken
// ----------------------------------------------------------------------------
module throughput_level_monitor #(
  parameter int NUM_IFACES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // iface[1:0], pkt_length[17:2], elapsed_ms[33:18]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // tx_bps[31:0], rx_bps[63:32], level[65:64], notify[66]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tlm_pkg::*;

  localparam int IFC_W = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;

  tlm_cmd_t         cmd;
  tlm_status_t      status;
  logic [IFC_W-1:0] ifc_sel;
  logic             side_sel;
  logic [31:0]      tx_bps;
  logic [31:0]      rx_bps;
  logic [1:0]       level;
  logic             notify;

  assign cfg_ready = 1'b1;

  tlm_ctrl #(
    .NUM_IFACES (NUM_IFACES),
    .IFC_W      (IFC_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .op       (op_t'(s_axis_tuser)),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd),
    .ifc_sel  (ifc_sel),
    .side_sel (side_sel)
  );

  tlm_datapath #(
    .NUM_IFACES (NUM_IFACES),
    .IFC_W      (IFC_W)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .ifc_sel    (ifc_sel),
    .side_sel   (side_sel),
    .iface      (s_axis_tdata[1:0]),
    .pkt_length (s_axis_tdata[17:2]),
    .elapsed_ms (s_axis_tdata[33:18]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_tx_bps (tx_bps),
    .out_rx_bps (rx_bps),
    .out_level  (level),
    .out_notify (notify)
  );

  assign m_axis_tdata = {5'd0, notify, level, rx_bps, tx_bps};

  // a tick or override word always leaves the input closed in the next cycle
  a_busy_after_result_word: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == OP_TICK || s_axis_tuser == OP_OVR)) |=> !s_axis_tready)
    else $error("input open right after tick or override word");

  // a new result is only loaded while the input side is closed
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a tick or override in flight");

endmodule
